// ===== hw/rtl/c8_pkg.sv =====
// Shared types, constants and the font table for the CHIP-8 instruction core.
package c8_pkg;

  localparam int MemDepth = 4096;
  localparam int AW = 12;
  localparam int StackDepth = 16;
  localparam int SPW = 4;
  localparam int FontLen = 80;
  localparam logic [AW-1:0] PcStart = 12'h200;
  localparam logic [7:0] Hundred = 8'd100;
  localparam logic [7:0] Ten = 8'd10;

  localparam logic [7:0] FONT [FontLen] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_PIXEL = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MWR, S_MRD, S_MCAP, S_PDIV, S_PRD, S_PCAP,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_WRF, S_CLR,
    S_DMX, S_DMY, S_DRD, S_DWR, S_BCD0, S_BCD1, S_BCD2,
    S_STRD, S_STWR, S_LDRD, S_LDWR, S_DONE
  } state_e;

  // major opcode nibbles
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OPW_CLS = 16'h00E0;
  localparam logic [15:0] OPW_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DN = 8'h9E;
  localparam logic [7:0] KEY_UP = 8'hA1;

  localparam logic [7:0] FX_GDT = 8'h07;
  localparam logic [7:0] FX_WK  = 8'h0A;
  localparam logic [7:0] FX_SDT = 8'h15;
  localparam logic [7:0] FX_SST = 8'h18;
  localparam logic [7:0] FX_ADI = 8'h1E;
  localparam logic [7:0] FX_FNT = 8'h29;
  localparam logic [7:0] FX_BCD = 8'h33;
  localparam logic [7:0] FX_STR = 8'h55;
  localparam logic [7:0] FX_LDR = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    logic [7:0] wdata;
    logic [3:0] raddr;
  } rf_req_t;

  // lowest numbered key that is down
  function automatic logic [3:0] first_key(logic [15:0] keys);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) k = 4'(i);
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/c8_mem.sv =====
// 4 KiB main memory, one write and one registered read port.
module c8_mem (
  input  logic              clk_i,
  input  c8_pkg::mem_req_t  req_i,
  output logic [7:0]        rdata_o
);
  import c8_pkg::*;

  logic [7:0] mem [MemDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ===== hw/rtl/c8_regs.sv =====
// V0..VF register file with registered read and per-entry valid bits.
module c8_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  c8_pkg::rf_req_t  req_i,
  output logic [7:0]       rdata_o
);
  import c8_pkg::*;

  logic [7:0]  regs [16];
  logic [15:0] vld_q;
  logic [7:0]  data_q;
  logic        rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) vld_q[req_i.waddr] <= 1'b1;
      rvld_q <= vld_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) regs[req_i.waddr] <= req_i.wdata;
    data_q <= regs[req_i.raddr];
  end

  assign rdata_o = rvld_q ? data_q : 8'd0;

endmodule

// ===== hw/rtl/c8_fb.sv =====
// Frame buffer, one row of pixels per entry, registered read.
module c8_fb #(
  parameter int W = 64,
  parameter int H = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(H)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(H)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] rows [H];

  always_ff @(posedge clk_i) begin
    if (we_i) rows[waddr_i] <= wdata_i;
    rdata_o <= rows[raddr_i];
  end

endmodule

// ===== hw/rtl/chip8_instruction_core.sv =====
// CHIP-8 instruction core: sequencer around main memory, registers and frame buffer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/in_stall_o  | cmd, address, write_data, key_mask, random_byte
//  out     | output    | out_valid_o/out_stall_i | pc_after, executed_opcode, read_data, ...
//
// One item at a time. Execute: F0..F4 fetch opcode and operands, then EXEC; draws read and
// write each row (up to 15 rows) after the origin wrap, clear walks SCREEN_H rows, FX55/FX65
// read and write each register. Memory commands access one byte; pixel reads divide the
// address by SCREEN_W first. A reset pass over all 4096 addresses loads the font, clears
// memory and frame buffer and takes no transfer. A stalled result waits in the output register.
module chip8_instruction_core #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] key_mask_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pc_after_o,
  output logic [15:0] executed_opcode_o,
  output logic [7:0]  read_data_o,
  output logic        screen_changed_o,
  output logic        waiting_key_o,
  output logic [7:0]  sound_value_o,
  output logic [7:0]  delay_value_o
);
  import c8_pkg::*;

  localparam int XW = $clog2(SCREEN_W);
  localparam int YW = $clog2(SCREEN_H);

  state_e state_q, state_d;

  logic [11:0]    cnt_q;
  logic [11:0]    addr_q;
  logic [7:0]     wdata_q;
  logic [15:0]    keys_q;
  logic [7:0]     rnd_q;
  logic [11:0]    pc_q;
  logic [15:0]    i_q;
  logic [SPW-1:0] sp_q;
  logic [11:0]    stk_q [StackDepth];
  logic [7:0]     dt_q, st_q;
  logic [15:0]    op_q;
  logic [7:0]     hi_q, vx_q, vy_q;
  logic           flag_q, flag_d;
  logic [11:0]    num_q, quo_q;
  logic [7:0]     x0_q, y0_q;
  logic [7:0]     rd_q;
  logic           chg_q, wait_q;
  logic           out_valid_q;
  logic           load_out;

  mem_req_t     mreq;
  logic [7:0]   mem_rdata;
  rf_req_t      rreq;
  logic [7:0]   rf_rdata;
  logic         fb_we;
  logic [YW-1:0] fb_waddr, fb_raddr;
  logic [SCREEN_W-1:0] fb_wdata, fb_rdata, spr_mask;

  logic [3:0] opc, ox, oy, on;
  logic [7:0] onn;
  logic [11:0] onnn;
  logic [YW:0] py;
  logic        accept;

  assign opc  = op_q[15:12];
  assign ox   = op_q[11:8];
  assign oy   = op_q[7:4];
  assign on   = op_q[3:0];
  assign onn  = op_q[7:0];
  assign onnn = op_q[11:0];
  assign py   = {1'b0, y0_q[YW-1:0]} + (YW+1)'(cnt_q[3:0]);
  assign accept = (state_q == S_IDLE) && in_valid_i;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  c8_mem u_mem (.clk_i, .req_i(mreq), .rdata_o(mem_rdata));
  c8_regs u_regs (.clk_i, .rst_ni, .req_i(rreq), .rdata_o(rf_rdata));
  c8_fb #(.W(SCREEN_W), .H(SCREEN_H)) u_fb (
    .clk_i, .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );

  // sprite row placed at x0, clipped at the right edge
  always_comb begin
    logic [XW:0] px;
    spr_mask = '0;
    for (int c = 0; c < 8; c++) begin
      px = {1'b0, x0_q[XW-1:0]} + (XW+1)'(c);
      if (mem_rdata[3'(7 - c)] && (px < (XW+1)'(SCREEN_W))) spr_mask[px[XW-1:0]] = 1'b1;
    end
  end

  // ALU result and flag for 8XYN
  logic [7:0] alu_res;
  logic [8:0] alu_sum;
  always_comb begin
    alu_sum = {1'b0, vx_q} + {1'b0, vy_q};
    alu_res = vy_q;
    flag_d  = 1'b0;
    case (on)
      ALU_OR:  alu_res = vx_q | vy_q;
      ALU_AND: alu_res = vx_q & vy_q;
      ALU_XOR: alu_res = vx_q ^ vy_q;
      ALU_ADD: begin alu_res = alu_sum[7:0]; flag_d = alu_sum[8]; end
      ALU_SUB: begin alu_res = vx_q - vy_q; flag_d = (vx_q >= vy_q); end
      ALU_SHR: begin alu_res = {1'b0, vy_q[7:1]}; flag_d = vy_q[0]; end
      ALU_SBN: begin alu_res = vy_q - vx_q; flag_d = (vy_q >= vx_q); end
      ALU_SHL: begin alu_res = {vy_q[6:0], 1'b0}; flag_d = vy_q[7]; end
      default: alu_res = vy_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: if (cnt_q == 12'hFFF) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_EXEC:  state_d = S_F0;
            CMD_WRITE: state_d = S_MWR;
            CMD_READ:  state_d = S_MRD;
            CMD_PIXEL: state_d = S_PDIV;
            default:   state_d = S_F0;
          endcase
        end
      end
      S_MWR:  state_d = S_DONE;
      S_MRD:  state_d = S_MCAP;
      S_MCAP: state_d = S_DONE;
      S_PDIV: begin
        if (num_q < 12'(SCREEN_W)) state_d = (quo_q >= 12'(SCREEN_H)) ? S_DONE : S_PRD;
      end
      S_PRD:  state_d = S_PCAP;
      S_PCAP: state_d = S_DONE;
      S_F0:   state_d = S_F1;
      S_F1:   state_d = S_F2;
      S_F2:   state_d = S_F3;
      S_F3:   state_d = S_F4;
      S_F4:   state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        case (opc)
          OP_SYS: if (op_q == OPW_CLS) state_d = S_CLR;
          OP_ALU: begin
            case (on)
              ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL:
                state_d = S_WRF;
              default: state_d = S_DONE;
            endcase
          end
          OP_DRW: state_d = S_DMX;
          OP_MISC: begin
            case (onn)
              FX_BCD:  state_d = S_BCD0;
              FX_STR:  state_d = S_STRD;
              FX_LDR:  state_d = S_LDRD;
              default: state_d = S_DONE;
            endcase
          end
          default: state_d = S_DONE;
        endcase
      end
      S_WRF: state_d = S_DONE;
      S_CLR: if (cnt_q == 12'(SCREEN_H - 1)) state_d = S_DONE;
      S_DMX: if (x0_q < 8'(SCREEN_W)) state_d = S_DMY;
      S_DMY: if (y0_q < 8'(SCREEN_H)) state_d = S_DRD;
      S_DRD: begin
        if ((cnt_q[3:0] == on) || (py >= (YW+1)'(SCREEN_H))) state_d = S_WRF;
        else state_d = S_DWR;
      end
      S_DWR:  state_d = S_DRD;
      S_BCD0: if (num_q[7:0] < Hundred) state_d = S_BCD1;
      S_BCD1: if (num_q[7:0] < Ten) state_d = S_BCD2;
      S_BCD2: state_d = S_DONE;
      S_STRD: state_d = S_STWR;
      S_STWR: state_d = (cnt_q[3:0] == ox) ? S_DONE : S_STRD;
      S_LDRD: state_d = S_LDWR;
      S_LDWR: state_d = (cnt_q[3:0] == ox) ? S_DONE : S_LDRD;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    mreq     = '0;
    rreq     = '0;
    fb_we    = 1'b0;
    fb_waddr = cnt_q[YW-1:0];
    fb_wdata = '0;
    fb_raddr = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = cnt_q;
        mreq.wdata = (cnt_q < 12'(FontLen)) ? FONT[cnt_q[6:0]] : 8'd0;
        fb_we      = (cnt_q < 12'(SCREEN_H));
      end
      S_MWR: begin
        mreq.we = 1'b1; mreq.waddr = addr_q; mreq.wdata = wdata_q;
      end
      S_MRD: mreq.raddr = addr_q;
      S_PRD: fb_raddr = quo_q[YW-1:0];
      S_F0:  mreq.raddr = pc_q;
      S_F1:  mreq.raddr = pc_q + 12'd1;
      S_F2:  rreq.raddr = (hi_q[7:4] == OP_JPV0) ? 4'd0 : hi_q[3:0];
      S_F3:  rreq.raddr = oy;
      S_EXEC: begin
        rreq.waddr = ox;
        case (opc)
          OP_LDI:  begin rreq.we = 1'b1; rreq.wdata = onn; end
          OP_ADDI: begin rreq.we = 1'b1; rreq.wdata = vx_q + onn; end
          OP_RND:  begin rreq.we = 1'b1; rreq.wdata = rnd_q & onn; end
          OP_ALU: begin
            case (on)
              ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL:
                begin rreq.we = 1'b1; rreq.wdata = alu_res; end
              default: rreq.we = 1'b0;
            endcase
          end
          OP_MISC: begin
            if (onn == FX_GDT) begin rreq.we = 1'b1; rreq.wdata = dt_q; end
            else if (onn == FX_WK && keys_q != 16'd0) begin
              rreq.we = 1'b1; rreq.wdata = {4'd0, first_key(keys_q)};
            end
          end
          default: rreq.we = 1'b0;
        endcase
      end
      S_WRF: begin
        rreq.we = 1'b1; rreq.waddr = REG_VF; rreq.wdata = {7'd0, flag_q};
      end
      S_CLR: fb_we = 1'b1;
      S_DRD: begin
        mreq.raddr = i_q[11:0] + {8'd0, cnt_q[3:0]};
        fb_raddr   = py[YW-1:0];
      end
      S_DWR: begin
        fb_we = 1'b1; fb_waddr = py[YW-1:0]; fb_wdata = fb_rdata ^ spr_mask;
      end
      S_BCD0: if (num_q[7:0] < Hundred) begin
        mreq.we = 1'b1; mreq.waddr = i_q[11:0]; mreq.wdata = quo_q[7:0];
      end
      S_BCD1: if (num_q[7:0] < Ten) begin
        mreq.we = 1'b1; mreq.waddr = i_q[11:0] + 12'd1; mreq.wdata = quo_q[7:0];
      end
      S_BCD2: begin
        mreq.we = 1'b1; mreq.waddr = i_q[11:0] + 12'd2; mreq.wdata = num_q[7:0];
      end
      S_STRD: rreq.raddr = cnt_q[3:0];
      S_STWR: begin
        mreq.we = 1'b1; mreq.waddr = i_q[11:0]; mreq.wdata = rf_rdata;
      end
      S_LDRD: mreq.raddr = i_q[11:0];
      S_LDWR: begin
        rreq.we = 1'b1; rreq.waddr = cnt_q[3:0]; rreq.wdata = mem_rdata;
      end
      default: mreq = '0;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      pc_q        <= PcStart;
      i_q         <= '0;
      sp_q        <= '0;
      dt_q        <= '0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < StackDepth; k++) stk_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_INIT: cnt_q <= cnt_q + 12'd1;
        S_IDLE: cnt_q <= '0;
        S_F2:   pc_q <= pc_q + 12'd2;
        S_EXEC: begin
          case (opc)
            OP_SYS: if (op_q == OPW_RET) begin
              pc_q <= stk_q[sp_q];
              sp_q <= sp_q - 1'b1;
            end
            OP_JP: pc_q <= onnn;
            OP_CALL: begin
              sp_q <= sp_q + 1'b1;
              stk_q[sp_q + 1'b1] <= pc_q;
              pc_q <= onnn;
            end
            OP_SEI:  if (vx_q == onn) pc_q <= pc_q + 12'd2;
            OP_SNEI: if (vx_q != onn) pc_q <= pc_q + 12'd2;
            OP_SER:  if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
            OP_SNER: if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
            OP_LDIX: i_q <= {4'd0, onnn};
            OP_JPV0: pc_q <= onnn + {4'd0, vx_q};
            OP_KEY: begin
              if (onn == KEY_DN && keys_q[vx_q[3:0]]) pc_q <= pc_q + 12'd2;
              else if (onn == KEY_UP && !keys_q[vx_q[3:0]]) pc_q <= pc_q + 12'd2;
            end
            OP_MISC: begin
              case (onn)
                FX_WK:  if (keys_q == 16'd0) pc_q <= pc_q - 12'd2;
                FX_SDT: dt_q <= vx_q;
                FX_SST: st_q <= vx_q;
                FX_ADI: i_q <= i_q + {8'd0, vx_q};
                FX_FNT: i_q <= {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
                default: i_q <= i_q;
              endcase
            end
            default: pc_q <= pc_q;
          endcase
        end
        S_CLR: cnt_q <= cnt_q + 12'd1;
        S_DWR: cnt_q <= cnt_q + 12'd1;
        S_STWR: begin i_q <= i_q + 16'd1; cnt_q <= cnt_q + 12'd1; end
        S_LDWR: begin i_q <= i_q + 16'd1; cnt_q <= cnt_q + 12'd1; end
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      keys_q  <= key_mask_i;
      rnd_q   <= random_byte_i;
      op_q    <= '0;
      rd_q    <= '0;
      chg_q   <= 1'b0;
      wait_q  <= 1'b0;
      num_q   <= address_i;
      quo_q   <= '0;
    end
    case (state_q)
      S_MCAP: rd_q <= mem_rdata;
      S_PDIV: if (num_q >= 12'(SCREEN_W)) begin
        num_q <= num_q - 12'(SCREEN_W);
        quo_q <= quo_q + 12'd1;
      end
      S_PCAP: rd_q <= {7'd0, fb_rdata[num_q[XW-1:0]]};
      S_F1:   hi_q <= mem_rdata;
      S_F2:   op_q <= {hi_q, mem_rdata};
      S_F3:   vx_q <= rf_rdata;
      S_F4:   vy_q <= rf_rdata;
      S_EXEC: begin
        // draw starts with VF cleared; the flag register collects collisions
        flag_q <= (opc == OP_ALU) ? flag_d : 1'b0;
        x0_q   <= vx_q;
        y0_q   <= vy_q;
        num_q  <= {4'd0, vx_q};
        quo_q  <= '0;
        if (opc == OP_SYS && op_q == OPW_CLS) chg_q <= 1'b1;
        if (opc == OP_DRW) chg_q <= 1'b1;
        if (opc == OP_MISC && onn == FX_WK && keys_q == 16'd0) wait_q <= 1'b1;
      end
      S_DMX: if (x0_q >= 8'(SCREEN_W)) x0_q <= x0_q - 8'(SCREEN_W);
      S_DMY: if (y0_q >= 8'(SCREEN_H)) y0_q <= y0_q - 8'(SCREEN_H);
      S_DWR: if (|(fb_rdata & spr_mask)) flag_q <= 1'b1;
      S_BCD0: begin
        if (num_q[7:0] >= Hundred) begin
          num_q <= num_q - {4'd0, Hundred};
          quo_q <= quo_q + 12'd1;
        end else quo_q <= '0;
      end
      S_BCD1: if (num_q[7:0] >= Ten) begin
        num_q <= num_q - {4'd0, Ten};
        quo_q <= quo_q + 12'd1;
      end
      default: hi_q <= hi_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pc_after_o        <= pc_q;
      executed_opcode_o <= op_q;
      read_data_o       <= rd_q;
      screen_changed_o  <= chg_q;
      waiting_key_o     <= wait_q;
      sound_value_o     <= st_q;
      delay_value_o     <= dt_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
